// File: rtl/core/cga_pkg.sv
// cga_pkg: shared types, register codes and palette tables for the CGA pixel
// colour generator. No dependencies.

package cga_pkg;

    // Register indexes, taken from paddr[2] (registers sit at byte 0 and 4)
    localparam int  CfgAddrWidth     = 3;
    localparam int  CfgIdxBit        = 2;
    localparam logic REG_MODE_CONTROL = 1'b0;
    localparam logic REG_COLOR_SELECT = 1'b1;

    // mode_control bits
    localparam int MODE_GRAPHICS = 1;
    localparam int MODE_MONO     = 2;
    localparam int MODE_ENABLE   = 3;
    localparam int MODE_HIRES    = 4;
    localparam int MODE_BLINK    = 5;

    // color_select bits
    localparam int SEL_INTENSE = 4;
    localparam int SEL_PALETTE = 5;

    typedef struct packed {
        logic [5:0] mode_control;
        logic [5:0] color_select;
    } cfg_t;

    typedef struct packed {
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic       blink_phase;
        logic [3:0] count;
    } cell_t;

    typedef struct packed {
        logic [23:0] rgb;
        logic [3:0]  index;
        logic        last;
    } pix_t;

    function automatic logic [23:0] colour_rgb(input logic [3:0] idx);
        logic [23:0] rgb;
        case (idx)
            4'd0:    rgb = 24'h000000;
            4'd1:    rgb = 24'h0000AA;
            4'd2:    rgb = 24'h00AA00;
            4'd3:    rgb = 24'h00AAAA;
            4'd4:    rgb = 24'hAA0000;
            4'd5:    rgb = 24'hAA00AA;
            4'd6:    rgb = 24'hAA5500;
            4'd7:    rgb = 24'hAAAAAA;
            4'd8:    rgb = 24'h555555;
            4'd9:    rgb = 24'h5555FF;
            4'd10:   rgb = 24'h55FF55;
            4'd11:   rgb = 24'h55FFFF;
            4'd12:   rgb = 24'hFF5555;
            4'd13:   rgb = 24'hFF55FF;
            4'd14:   rgb = 24'hFFFF55;
            default: rgb = 24'hFFFFFF;
        endcase
        return rgb;
    endfunction

    function automatic logic [23:0] grey_rgb(input logic [3:0] idx);
        logic [23:0] rgb;
        case (idx)
            4'd0:    rgb = 24'h000000;
            4'd1:    rgb = 24'h0C0C0C;
            4'd2:    rgb = 24'h7A7A7A;
            4'd3:    rgb = 24'h868686;
            4'd4:    rgb = 24'h242424;
            4'd5:    rgb = 24'h303030;
            4'd6:    rgb = 24'h616161;
            4'd7:    rgb = 24'hAAAAAA;
            4'd8:    rgb = 24'h555555;
            4'd9:    rgb = 24'h616161;
            4'd10:   rgb = 24'hCFCFCF;
            4'd11:   rgb = 24'hDBDBDB;
            4'd12:   rgb = 24'h797979;
            4'd13:   rgb = 24'h858585;
            4'd14:   rgb = 24'hF3F3F3;
            default: rgb = 24'hFFFFFF;
        endcase
        return rgb;
    endfunction

endpackage

// File: rtl/core/cga_if.sv
// cga_if: valid/ready channel interfaces for character cells in and pixels out.
// No dependencies.

interface cga_cell_if;
    logic       valid;
    logic       ready;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic       visible;
    logic       blink_phase;

    modport source (output valid, first_byte, second_byte, visible, blink_phase,
                    input ready);
    modport sink   (input valid, first_byte, second_byte, visible, blink_phase,
                    output ready);
endinterface

interface cga_pix_if;
    logic        valid;
    logic        ready;
    logic [23:0] pixel_rgb;
    logic [3:0]  pixel_index;
    logic        last_pixel;

    modport source (output valid, pixel_rgb, pixel_index, last_pixel, input ready);
    modport sink   (input valid, pixel_rgb, pixel_index, last_pixel, output ready);
endinterface

// File: rtl/core/cga_cfg_regs.sv
// cga_cfg_regs: APB-style register file for mode_control and color_select.
// Depends on cga_pkg.

module cga_cfg_regs
    import cga_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [CfgAddrWidth-1:0] paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    output cfg_t                    cfg
);

    logic [5:0] mode_control_reg;
    logic [5:0] color_select_reg;
    logic [5:0] mode_control_next;
    logic [5:0] color_select_next;
    logic       wr_en;
    logic       reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[CfgIdxBit];

    always_comb
    begin
        mode_control_next = mode_control_reg;
        color_select_next = color_select_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_MODE_CONTROL: mode_control_next = pwdata[5:0];
                REG_COLOR_SELECT: color_select_next = pwdata[5:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_control_reg <= '0;
            color_select_reg <= '0;
        end
        else
        begin
            mode_control_reg <= mode_control_next;
            color_select_reg <= color_select_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_MODE_CONTROL: prdata = {26'd0, mode_control_reg};
            REG_COLOR_SELECT: prdata = {26'd0, color_select_reg};
            default:          prdata = '0;
        endcase
    end

    assign cfg.mode_control = mode_control_reg;
    assign cfg.color_select = color_select_reg;

endmodule

// File: rtl/core/cga_pix_decode.sv
// cga_pix_decode: picks the palette index and RGB of one pixel of a cell.
// Depends on cga_pkg.

module cga_pix_decode
    import cga_pkg::*;
(
    input  cfg_t  cfg,
    input  cell_t cell_q,
    output pix_t  pix
);

    logic [15:0] bits;
    logic [3:0]  cnt;
    logic [1:0]  pair;
    logic        hi_bit;
    logic        font_bit;
    logic [3:0]  colour;
    logic [3:0]  fg;
    logic [3:0]  bg;
    logic        blinking;
    logic        hires;
    logic [3:0]  idx;

    assign bits     = {cell_q.first_byte, cell_q.second_byte};
    assign cnt      = cell_q.count;
    assign hires    = cfg.mode_control[MODE_HIRES];
    assign colour   = cfg.color_select[3:0];
    // pixel c of 16: bit 15-c; pixel c of 8: pair at 15-2c; font bit 7-c
    assign hi_bit   = bits[~cnt];
    assign pair     = bits[{~cnt[2:0], 1'b1} -: 2];
    assign font_bit = cell_q.first_byte[~cnt[2:0]];

    assign fg       = cell_q.second_byte[3:0];
    assign blinking = cfg.mode_control[MODE_BLINK] && cell_q.second_byte[7];
    assign bg       = cfg.mode_control[MODE_BLINK] ? {1'b0, cell_q.second_byte[6:4]}
                                                   : cell_q.second_byte[7:4];

    always_comb
    begin
        if (hires)
            idx = hi_bit ? colour : 4'd0;
        else if (cfg.mode_control[MODE_GRAPHICS])
            idx = (pair != 2'd0) ? {cfg.color_select[SEL_INTENSE], pair,
                                    cfg.color_select[SEL_PALETTE]}
                                 : colour;
        else
            idx = ((!blinking || cell_q.blink_phase) && font_bit) ? fg : bg;
    end

    assign pix.index = idx;
    assign pix.rgb   = cfg.mode_control[MODE_MONO] ? grey_rgb(idx) : colour_rgb(idx);
    assign pix.last  = hires ? (cnt == 4'd15) : (cnt[2:0] == 3'd7);

endmodule

// File: rtl/core/cga_pixel_colour_generator.sv
// cga_pixel_colour_generator: top level; cell register, pixel counter and
// output register around cga_pix_decode. Depends on cga_pkg, cga_if,
// cga_cfg_regs and cga_pix_decode.
//
//  channel  | dir | handshake    | payload
//  ---------+-----+--------------+-------------------------------------------
//  video    | in  | valid/ready  | first_byte, second_byte, visible, blink_phase
//  pixels   | out | valid/ready  | pixel_rgb, pixel_index, last_pixel
//  apb      | in  | psel/penable | paddr, pwdata, prdata (pready tied high)
//
// A shown cell gives one pixel per cycle unless pixels stalls: 8 pixels in
// text and 320 mode, 16 in 640 mode, set by the single pixel counter. A cell that
// gives no pixels is dropped on acceptance. The next cell is taken in the cycle its
// predecessor's last pixel moves to the output register, so pixels stream
// without gaps. A stall on pixels holds the output register and the counter.
// Reset clears the registers, the cell and output valid flags.

module cga_pixel_colour_generator
    import cga_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [CfgAddrWidth-1:0] paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    cga_cell_if.sink                video,
    cga_pix_if.source               pixels
);

    cfg_t  cfg;
    cell_t cell_reg;
    cell_t cell_next;
    logic  cell_valid_reg;
    logic  cell_valid_next;
    pix_t  pix;
    pix_t  pix_reg;
    pix_t  pix_next;
    logic  out_valid_reg;
    logic  out_valid_next;
    logic  out_free;
    logic  emit;
    logic  cell_done;
    logic  accept;
    logic  shown;

    cga_cfg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cga_pix_decode u_decode (
        .cfg    (cfg),
        .cell_q (cell_reg),
        .pix    (pix)
    );

    assign out_free    = !out_valid_reg || pixels.ready;
    assign emit        = cell_valid_reg && out_free;
    assign cell_done   = emit && pix.last;
    assign video.ready = !cell_valid_reg || cell_done;
    assign accept      = video.valid && video.ready;
    assign shown       = video.visible && cfg.mode_control[MODE_ENABLE];

    always_comb
    begin
        cell_next       = cell_reg;
        cell_valid_next = cell_valid_reg;
        if (accept)
        begin
            cell_next.first_byte  = video.first_byte;
            cell_next.second_byte = video.second_byte;
            cell_next.blink_phase = video.blink_phase;
            cell_next.count       = 4'd0;
            cell_valid_next       = shown;
        end
        else if (emit)
        begin
            cell_next.count = cell_reg.count + 4'd1;
            if (cell_done)
                cell_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        pix_next       = pix_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            pix_next       = pix;
            out_valid_next = 1'b1;
        end
        else if (pixels.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cell_valid_reg <= cell_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
        pix_reg  <= pix_next;
    end

    assign pixels.valid       = out_valid_reg;
    assign pixels.pixel_rgb   = pix_reg.rgb;
    assign pixels.pixel_index = pix_reg.index;
    assign pixels.last_pixel  = pix_reg.last;

    // 8-pixel cells never count past 7
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid_reg && !cfg.mode_control[MODE_HIRES] |-> !cell_reg.count[3])
        else $error("pixel counter ran past an 8-pixel cell");

    // a new cell is taken only when the current one is finishing
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        video.ready && cell_valid_reg |-> cell_done)
        else $error("cell taken while pixels remain");

    // after the last pixel the counter restarts or the cell empties
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cell_done |=> !cell_valid_reg || cell_reg.count == 4'd0)
        else $error("counter did not restart after last pixel");

    // a pixel is only moved when it has somewhere to go
    a_out_slot: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> out_valid_reg)
        else $error("emitted pixel lost from output register");

endmodule
